// ----- sv/gost_feistel_block_cipher_unit_macros.svh -----
// assertion helpers used by the cipher top level
`ifndef GOST_FEISTEL_BLOCK_CIPHER_UNIT_MACROS_SVH
`define GOST_FEISTEL_BLOCK_CIPHER_UNIT_MACROS_SVH

// checked only while out of reset
`define GOST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define GOST_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- sv/gost_pkg.sv -----
`default_nettype none

package gost_pkg;

    localparam int unsigned ROUND_COUNT  = 32;
    localparam int unsigned ROTATE_BITS  = 11;
    localparam int unsigned ENC_FORWARD  = 24;
    localparam int unsigned DEC_FORWARD  = 8;
    localparam int unsigned KEY_WORDS    = 8;
    localparam int unsigned WORD_W       = 32;
    localparam int unsigned BLOCK_W      = 64;
    localparam int unsigned CFG_INDEX_W  = 4;

    // operation codes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [3:0]        nibble_t;
    typedef logic [2:0]        key_idx_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_array_t;

    // data carried from one round cell to the next
    typedef struct packed {
        logic  op;
        word_t n1;
        word_t n2;
    } stage_t;

    // substitution rows, one row per key index
    localparam nibble_t SBOX [8][16] = '{
        '{4'hF, 4'hC, 4'h2, 4'hA, 4'h6, 4'h4, 4'h5, 4'h0,
          4'h7, 4'h9, 4'hE, 4'hD, 4'h1, 4'hB, 4'h8, 4'h3},
        '{4'hB, 4'h6, 4'h3, 4'h4, 4'hC, 4'hF, 4'hE, 4'h2,
          4'h7, 4'hD, 4'h8, 4'h0, 4'h5, 4'hA, 4'h9, 4'h1},
        '{4'h1, 4'hC, 4'hB, 4'h0, 4'hF, 4'hE, 4'h6, 4'h5,
          4'hA, 4'hD, 4'h4, 4'h8, 4'h9, 4'h3, 4'h7, 4'h2},
        '{4'h1, 4'h5, 4'hE, 4'hC, 4'hA, 4'h7, 4'h0, 4'hD,
          4'h6, 4'h2, 4'hB, 4'h4, 4'h9, 4'h3, 4'hF, 4'h8},
        '{4'h0, 4'hC, 4'h8, 4'h9, 4'hD, 4'h2, 4'hA, 4'hB,
          4'h7, 4'h3, 4'h6, 4'h5, 4'h4, 4'hE, 4'hF, 4'h1},
        '{4'h8, 4'h0, 4'hF, 4'h3, 4'h2, 4'h5, 4'hE, 4'hB,
          4'h1, 4'hA, 4'h4, 4'h7, 4'hC, 4'h9, 4'hD, 4'h6},
        '{4'h3, 4'h0, 4'h6, 4'hF, 4'h1, 4'hE, 4'h9, 4'h2,
          4'hD, 4'h8, 4'hC, 4'h4, 4'hB, 4'hA, 4'h5, 4'h7},
        '{4'h1, 4'hA, 4'h6, 4'h8, 4'hF, 4'hB, 4'h0, 4'h4,
          4'hC, 4'h3, 4'h5, 4'h9, 4'h7, 4'hD, 4'h2, 4'hE}
    };

    // all eight nibbles through the same row
    function automatic word_t sub_word(input key_idx_t row, input word_t v);
        word_t r;
        r = '0;
        for (int n = 0; n < 8; n++) begin
            r[4*n +: 4] = SBOX[row][v[4*n +: 4]];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/gost_feistel_block_cipher_unit.sv -----
// GOST style 64-bit Feistel block cipher, 32 rounds, electronic codebook.
// Input channel s_*: s_operation (0 encrypt, 1 decrypt) and s_block_in, high
// half N1, low half N2. Result channel m_*: m_block_out, final N2 in the high
// half and final N1 in the low half. Both use valid/ready handshakes.
// Key port cfg_*: cfg_index 0..7 selects a 32-bit key word, cfg_data is the
// word; cfg_ready is always high and indices above 7 are dropped. Keys are
// only to be changed while no item is in flight.
// A row of 32 round cells, one per round, each holding one item. An item
// appears on m_valid after passing through every cell in turn; one item per
// cycle is taken while the receiver keeps m_ready high. The last cell is the
// output register.
// When the receiver stalls with a result waiting, the whole row holds and
// s_ready drops; empty slots in the row still move up while the output
// register is empty.
// Synchronous reset clears all valid bits and all key words to zero.
`default_nettype none

module gost_feistel_block_cipher_unit (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire                              s_operation,
    input  wire [gost_pkg::BLOCK_W-1:0]      s_block_in,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [gost_pkg::BLOCK_W-1:0]     m_block_out,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [gost_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire [gost_pkg::WORD_W-1:0]       cfg_data
);
    import gost_pkg::*;

    `include "gost_feistel_block_cipher_unit_macros.svh"

    key_array_t key_reg;
    logic       advance;
    logic       stage_valid [ROUND_COUNT+1];
    stage_t     stage_data  [ROUND_COUNT+1];

    // key word registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_valid && (cfg_index < CFG_INDEX_W'(KEY_WORDS))) begin
            key_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // the row moves whenever the output register is free or being read
    assign advance = !stage_valid[ROUND_COUNT] || m_ready;
    assign s_ready = advance;

    // entry into the first cell
    always_comb begin
        stage_valid[0]   = s_valid;
        stage_data[0].op = s_operation;
        stage_data[0].n1 = s_block_in[BLOCK_W-1:WORD_W];
        stage_data[0].n2 = s_block_in[WORD_W-1:0];
    end

    // row of round cells
    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        gost_round_cell #(
            .STAGE (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .key_words (key_reg),
            .in_valid  (stage_valid[g]),
            .in_data   (stage_data[g]),
            .out_valid (stage_valid[g+1]),
            .out_data  (stage_data[g+1])
        );
    end

    // result is N2:N1 after the last round
    assign m_valid     = stage_valid[ROUND_COUNT];
    assign m_block_out = {stage_data[ROUND_COUNT].n2, stage_data[ROUND_COUNT].n1};

    `GOST_ASSERT_ALWAYS(a_no_result_after_reset, !aresetn |=> !m_valid, "valid after reset")
    `GOST_ASSERT(a_accept_enters_row, s_valid && s_ready |=> stage_valid[1], "entry lost")
    `GOST_ASSERT(a_stall_keeps_valid, m_valid && !m_ready |=> m_valid, "valid dropped")
    `GOST_ASSERT(a_stall_holds, m_valid && !m_ready |=> $stable(m_block_out), "output moved")

endmodule

`default_nettype wire

// ----- sv/gost_round_cell.sv -----
`default_nettype none

module gost_round_cell #(
    parameter int unsigned STAGE = 0
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  advance,
    input  wire gost_pkg::key_array_t key_words,
    input  wire                  in_valid,
    input  wire gost_pkg::stage_t in_data,
    output logic                 out_valid,
    output gost_pkg::stage_t     out_data
);
    import gost_pkg::*;

    // key index used by this round for each direction
    localparam key_idx_t FWD_IDX = key_idx_t'(STAGE % KEY_WORDS);
    localparam key_idx_t REV_IDX = key_idx_t'((KEY_WORDS - 1) - (STAGE % KEY_WORDS));
    localparam key_idx_t ENC_IDX = (STAGE < ENC_FORWARD) ? FWD_IDX : REV_IDX;
    localparam key_idx_t DEC_IDX = (STAGE < DEC_FORWARD) ? FWD_IDX : REV_IDX;

    key_idx_t key_sel;
    word_t    sum;
    word_t    subst;
    word_t    f_out;
    logic     valid_reg;
    logic     valid_next;
    stage_t   data_reg;
    stage_t   data_next;

    // round function: add key, substitute, rotate
    always_comb begin
        key_sel = (in_data.op == OP_DECRYPT) ? DEC_IDX : ENC_IDX;
        sum     = in_data.n1 + key_words[key_sel];
        subst   = sub_word(key_sel, sum);
        f_out   = (subst << ROTATE_BITS) | (subst >> (WORD_W - ROTATE_BITS));
    end

    // feistel swap
    always_comb begin
        data_next.op = in_data.op;
        data_next.n1 = f_out ^ in_data.n2;
        data_next.n2 = in_data.n1;
        valid_next   = in_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- tb/gost_feistel_block_cipher_unit_test.sv -----
`timescale 1ns / 1ps

module gost_feistel_block_cipher_unit_test;

    import gost_pkg::*;

    localparam int unsigned FLUSH_CYCLES = 40;
    localparam int unsigned CFG_SLOTS    = 1 << CFG_INDEX_W;
    localparam logic [WORD_W-1:0] WORD_ONES = '1;

    // substitution rows of this cipher variant, one per key index
    localparam logic [3:0] SUB_ROWS [8][16] = '{
        '{4'hF, 4'hC, 4'h2, 4'hA, 4'h6, 4'h4, 4'h5, 4'h0,
          4'h7, 4'h9, 4'hE, 4'hD, 4'h1, 4'hB, 4'h8, 4'h3},
        '{4'hB, 4'h6, 4'h3, 4'h4, 4'hC, 4'hF, 4'hE, 4'h2,
          4'h7, 4'hD, 4'h8, 4'h0, 4'h5, 4'hA, 4'h9, 4'h1},
        '{4'h1, 4'hC, 4'hB, 4'h0, 4'hF, 4'hE, 4'h6, 4'h5,
          4'hA, 4'hD, 4'h4, 4'h8, 4'h9, 4'h3, 4'h7, 4'h2},
        '{4'h1, 4'h5, 4'hE, 4'hC, 4'hA, 4'h7, 4'h0, 4'hD,
          4'h6, 4'h2, 4'hB, 4'h4, 4'h9, 4'h3, 4'hF, 4'h8},
        '{4'h0, 4'hC, 4'h8, 4'h9, 4'hD, 4'h2, 4'hA, 4'hB,
          4'h7, 4'h3, 4'h6, 4'h5, 4'h4, 4'hE, 4'hF, 4'h1},
        '{4'h8, 4'h0, 4'hF, 4'h3, 4'h2, 4'h5, 4'hE, 4'hB,
          4'h1, 4'hA, 4'h4, 4'h7, 4'hC, 4'h9, 4'hD, 4'h6},
        '{4'h3, 4'h0, 4'h6, 4'hF, 4'h1, 4'hE, 4'h9, 4'h2,
          4'hD, 4'h8, 4'hC, 4'h4, 4'hB, 4'hA, 4'h5, 4'h7},
        '{4'h1, 4'hA, 4'h6, 4'h8, 4'hF, 4'hB, 4'h0, 4'h4,
          4'hC, 4'h3, 4'h5, 4'h9, 4'h7, 4'hD, 4'h2, 4'hE}
    };

    typedef struct packed {
        logic               op;
        logic [BLOCK_W-1:0] blk;
    } cipher_req_t;

    logic                     aclk        = 1'b0;
    logic                     aresetn     = 1'b0;
    logic                     s_valid     = 1'b0;
    logic                     s_ready;
    logic                     s_operation = OP_ENCRYPT;
    logic [BLOCK_W-1:0]       s_block_in  = '0;
    logic                     m_valid;
    logic                     m_ready     = 1'b0;
    logic [BLOCK_W-1:0]       m_block_out;
    logic                     cfg_valid   = 1'b0;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index   = '0;
    logic [WORD_W-1:0]        cfg_data    = '0;

    cipher_req_t        pending_reqs [$];
    logic [BLOCK_W-1:0] expected_blocks [$];
    logic [WORD_W-1:0]  key_model [KEY_WORDS];
    int unsigned        send_idle_pct = 0;
    int unsigned        recv_stall_pct = 0;
    int unsigned        error_count = 0;

    gost_feistel_block_cipher_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_block_in  (s_block_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_block_out (m_block_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // 32 feistel rounds under the current key words
    function automatic logic [BLOCK_W-1:0] cipher_block(input logic op,
                                                        input logic [BLOCK_W-1:0] blk);
        logic [WORD_W-1:0] n1, n2, f, sb, t;
        int unsigned       fwd;
        int unsigned       k;
        n1  = blk[BLOCK_W-1:WORD_W];
        n2  = blk[WORD_W-1:0];
        fwd = (op == OP_DECRYPT) ? DEC_FORWARD : ENC_FORWARD;
        for (int unsigned r = 0; r < ROUND_COUNT; r++) begin
            k = (r < fwd) ? (r % 8) : (7 - (r % 8));
            f = n1 + key_model[k];
            for (int n = 0; n < 8; n++) begin
                sb[4*n +: 4] = SUB_ROWS[k][f[4*n +: 4]];
            end
            f  = (sb << ROTATE_BITS) | (sb >> (WORD_W - ROTATE_BITS));
            t  = n1;
            n1 = f ^ n2;
            n2 = t;
        end
        return {n2, n1};
    endfunction

    // random half, biased towards carry and sign corners
    function automatic logic [WORD_W-1:0] rand_half();
        case ($urandom_range(9))
            0: return '0;
            1: return WORD_ONES;
            2: return 32'h8000_0000;
            3: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // key word write, caller lowers cfg_valid after the burst
    task automatic write_key(input int unsigned idx, input logic [WORD_W-1:0] value);
        logic [CFG_INDEX_W-1:0] slot;
        slot = idx[CFG_INDEX_W-1:0];
        cfg_valid <= 1'b1;
        cfg_index <= slot;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx < KEY_WORDS) key_model[idx] = value;
    endtask

    // wait for the pipe to empty, then let it settle
    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_reqs.size() != 0 || s_valid || expected_blocks.size() != 0);
        repeat (FLUSH_CYCLES) @(posedge aclk);
    endtask

    // corner blocks for both directions
    task automatic queue_corner_blocks();
        logic [BLOCK_W-1:0] corners [6];
        corners = '{64'h0, '1, 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF,
                    64'h8000_0000_0000_0001, 64'h0123_4567_89AB_CDEF};
        foreach (corners[i]) begin
            pending_reqs.push_back('{op: OP_ENCRYPT, blk: corners[i]});
            pending_reqs.push_back('{op: OP_DECRYPT, blk: corners[i]});
        end
    endtask

    // random traffic, a share of it as pairs whose second item applies the opposite operation to the first result
    task automatic queue_random_blocks(input int unsigned count);
        logic [BLOCK_W-1:0] blk;
        logic               op;
        int unsigned        queued;
        queued = 0;
        while (queued < count) begin
            blk = {rand_half(), rand_half()};
            op  = $urandom_range(1) ? OP_DECRYPT : OP_ENCRYPT;
            if ($urandom_range(3) == 0) begin
                pending_reqs.push_back('{op: op, blk: blk});
                pending_reqs.push_back('{op: ~op, blk: cipher_block(op, blk)});
                queued += 2;
            end else begin
                pending_reqs.push_back('{op: op, blk: blk});
                queued += 1;
            end
        end
    endtask

    // sender: next item once the current one is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cipher_req_t req;
                req = pending_reqs.pop_front();
                s_valid     <= 1'b1;
                s_operation <= req.op;
                s_block_in  <= req.blk;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // predict on accepted items, check accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_blocks.push_back(cipher_block(s_operation, s_block_in));
            end
            if (m_valid && m_ready) begin
                if (expected_blocks.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_block_out);
                    error_count++;
                end else begin
                    logic [BLOCK_W-1:0] want;
                    want = expected_blocks.pop_front();
                    if (m_block_out !== want) begin
                        $display("%0t: block_out mismatch, expected %h, actual %h",
                                 $time, want, m_block_out);
                        error_count++;
                    end
                end
            end
        end
    end

    // stimulus sequence
    initial begin
        foreach (key_model[i]) key_model[i] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // keys as left by reset
        send_idle_pct  = 15;
        recv_stall_pct = 45;
        queue_corner_blocks();
        wait_drained();

        // all key bits set, round sums overflow
        for (int unsigned i = 0; i < KEY_WORDS; i++) write_key(i, WORD_ONES);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        queue_corner_blocks();
        queue_random_blocks(270);
        wait_drained();

        // random keys, writes to unused slots must be dropped
        send_idle_pct  = 45;
        recv_stall_pct = 15;
        for (int unsigned i = 0; i < KEY_WORDS; i++) write_key(i, $urandom);
        for (int unsigned i = KEY_WORDS; i < CFG_SLOTS; i++) write_key(i, $urandom);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        queue_random_blocks(300);
        wait_drained();

        // mixed extremes and random words, no idling
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int unsigned i = KEY_WORDS; i > 0; i--) begin
            case (i % 4)
                0: write_key(i - 1, '0);
                1: write_key(i - 1, 32'h8000_0000);
                2: write_key(i - 1, 32'h0000_0001);
                default: write_key(i - 1, $urandom);
            endcase
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
        queue_random_blocks(300);
        wait_drained();

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
